// ----- sv/psbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbm_pkg
// Shared types and constants of the patch ssd best match block.
// ----------------------------------------------------------------------------
package psbm_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned OvlW    = 40;
  localparam int unsigned LumSumW = 48;
  localparam int unsigned ScoreW  = 48;
  localparam int unsigned WsumW   = 22;
  localparam int unsigned NumW    = 16;
  localparam int unsigned AccW    = 57;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [13:0] LumDiv    = 14'd10000;
  localparam logic [18:0] LumRecip  = 19'd429496;
  localparam logic [11:0] CoefR     = 12'd2126;
  localparam logic [12:0] CoefG     = 13'd7152;
  localparam logic [9:0]  CoefB     = 10'd722;
  localparam logic [8:0]  AlphaOne  = 9'd256;

  localparam logic [CntW-1:0] DivLast   = 4'd15;
  localparam logic [CntW-1:0] BlendLast = 4'd8;

  localparam logic [CfgIdxW-1:0] RegMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAlpha  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinSrc = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxSrc = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinMap = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxMap = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StAcc,
    StLumMul,
    StLumFix,
    StNormInit,
    StDiv,
    StLumAcc,
    StBlendInit,
    StBlend,
    StClose
  } state_e;

  typedef struct packed {
    logic load;
    logic acc;
    logic lum_mul;
    logic lum_fix;
    logic norm_init;
    logic div_step;
    logic lum_acc;
    logic blend_init;
    logic blend_step;
    logic close;
  } dp_cmd_t;

  typedef struct packed {
    logic corr_path;
    logic last;
    logic mode;
  } dp_status_t;

endpackage

// ----- sv/psbm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbm_ctrl
// Sequencer for item intake, luminance division, blend and closing.
// ----------------------------------------------------------------------------
module psbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  psbm_pkg::dp_status_t status_i,
  output psbm_pkg::dp_cmd_t    cmd_o
);

  psbm_pkg::state_e state_q, state_d;
  logic [psbm_pkg::CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == psbm_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      psbm_pkg::StIdle: begin
        if (in_valid_i) state_d = psbm_pkg::StAcc;
      end
      psbm_pkg::StAcc: begin
        if (status_i.corr_path) state_d = psbm_pkg::StLumMul;
        else if (!status_i.last) state_d = psbm_pkg::StIdle;
        else if (status_i.mode) state_d = psbm_pkg::StBlendInit;
        else state_d = psbm_pkg::StClose;
      end
      psbm_pkg::StLumMul:   state_d = psbm_pkg::StLumFix;
      psbm_pkg::StLumFix:   state_d = psbm_pkg::StNormInit;
      psbm_pkg::StNormInit: begin
        state_d = psbm_pkg::StDiv;
        cnt_d   = '0;
      end
      psbm_pkg::StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == psbm_pkg::DivLast) state_d = psbm_pkg::StLumAcc;
      end
      psbm_pkg::StLumAcc: begin
        if (status_i.last) state_d = psbm_pkg::StBlendInit;
        else state_d = psbm_pkg::StIdle;
      end
      psbm_pkg::StBlendInit: begin
        state_d = psbm_pkg::StBlend;
        cnt_d   = '0;
      end
      psbm_pkg::StBlend: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == psbm_pkg::BlendLast) state_d = psbm_pkg::StClose;
      end
      psbm_pkg::StClose: begin
        if (slot_free) state_d = psbm_pkg::StIdle;
      end
      default: state_d = psbm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      psbm_pkg::StIdle:      cmd_o.load       = in_valid_i;
      psbm_pkg::StAcc:       cmd_o.acc        = 1'b1;
      psbm_pkg::StLumMul:    cmd_o.lum_mul    = 1'b1;
      psbm_pkg::StLumFix:    cmd_o.lum_fix    = 1'b1;
      psbm_pkg::StNormInit:  cmd_o.norm_init  = 1'b1;
      psbm_pkg::StDiv:       cmd_o.div_step   = 1'b1;
      psbm_pkg::StLumAcc:    cmd_o.lum_acc    = 1'b1;
      psbm_pkg::StBlendInit: cmd_o.blend_init = 1'b1;
      psbm_pkg::StBlend:     cmd_o.blend_step = 1'b1;
      psbm_pkg::StClose: begin
        cmd_o.close = slot_free;
        if (slot_free) out_valid_d = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psbm_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/psbm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbm_dp
// Registers, squared error sums, luminance divider, blend and best search.
// ----------------------------------------------------------------------------
module psbm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  input  logic [71:0]          in_data_i,
  input  logic [2:0]           in_user_i,
  input  logic                 in_last_i,
  output logic [119:0]         out_data_o,
  input  psbm_pkg::dp_cmd_t    cmd_i,
  output psbm_pkg::dp_status_t status_o
);

  // configuration
  logic       mode_q;
  logic [8:0] alpha_q;
  logic [7:0] min_src_q, max_src_q, min_map_q, max_map_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      alpha_q   <= 9'd128;
      min_src_q <= 8'd0;
      max_src_q <= 8'd255;
      min_map_q <= 8'd0;
      max_map_q <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psbm_pkg::RegMode:   mode_q    <= cfg_data_i[0];
        psbm_pkg::RegAlpha:  alpha_q   <= cfg_data_i;
        psbm_pkg::RegMinSrc: min_src_q <= cfg_data_i[7:0];
        psbm_pkg::RegMaxSrc: max_src_q <= cfg_data_i[7:0];
        psbm_pkg::RegMinMap: min_map_q <= cfg_data_i[7:0];
        psbm_pkg::RegMaxMap: max_map_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        cmd_q, inb_q, last_q;
  logic [11:0] cx_q, cy_q;
  logic [7:0]  sr_q, sg_q, sb_q, rr_q, rg_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_user_i[0];
      inb_q  <= in_user_i[2];
      last_q <= in_last_i;
      cx_q   <= in_data_i[11:0];
      cy_q   <= in_data_i[23:12];
      sr_q   <= in_data_i[31:24];
      sg_q   <= in_data_i[39:32];
      sb_q   <= in_data_i[47:40];
      rr_q   <= in_data_i[55:48];
      rg_q   <= in_data_i[63:56];
      rb_q   <= in_data_i[71:64];
    end
  end

  assign status_o.corr_path = inb_q && cmd_q && mode_q;
  assign status_o.last      = last_q;
  assign status_o.mode      = mode_q;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [psbm_pkg::WsumW-1:0] wsum(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
    wsum = psbm_pkg::WsumW'(r) * psbm_pkg::WsumW'(psbm_pkg::CoefR)
         + psbm_pkg::WsumW'(g) * psbm_pkg::WsumW'(psbm_pkg::CoefG)
         + psbm_pkg::WsumW'(b) * psbm_pkg::WsumW'(psbm_pkg::CoefB);
  endfunction

  // overlap error
  logic [7:0]  dr, dg, db;
  logic [17:0] ovl_err;
  logic [40:0] ovl_add;
  logic [psbm_pkg::OvlW-1:0] ovl_sum_q;

  assign dr      = absdiff(sr_q, rr_q);
  assign dg      = absdiff(sg_q, rg_q);
  assign db      = absdiff(sb_q, rb_q);
  assign ovl_err = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
  assign ovl_add = {1'b0, ovl_sum_q} + 41'(ovl_err);

  // luminance
  logic [psbm_pkg::WsumW-1:0] ws_src_q, ws_map_q;
  logic [7:0] q0_src_q, q0_map_q, lum_src_q, lum_map_q;
  logic [40:0] prod_src, prod_map;
  logic [psbm_pkg::WsumW-1:0] rem_src, rem_map;

  assign prod_src = 41'(ws_src_q) * 41'(psbm_pkg::LumRecip);
  assign prod_map = 41'(ws_map_q) * 41'(psbm_pkg::LumRecip);
  assign rem_src  = ws_src_q - psbm_pkg::WsumW'(q0_src_q) * psbm_pkg::WsumW'(psbm_pkg::LumDiv);
  assign rem_map  = ws_map_q - psbm_pkg::WsumW'(q0_map_q) * psbm_pkg::WsumW'(psbm_pkg::LumDiv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      ws_src_q <= wsum(sr_q, sg_q, sb_q);
      ws_map_q <= wsum(rr_q, rg_q, rb_q);
    end
    if (cmd_i.lum_mul) begin
      q0_src_q <= prod_src[39:32];
      q0_map_q <= prod_map[39:32];
    end
    if (cmd_i.lum_fix) begin
      lum_src_q <= (rem_src >= psbm_pkg::WsumW'(psbm_pkg::LumDiv)) ? q0_src_q + 1'b1 : q0_src_q;
      lum_map_q <= (rem_map >= psbm_pkg::WsumW'(psbm_pkg::LumDiv)) ? q0_map_q + 1'b1 : q0_map_q;
    end
  end

  // normalization setup and restoring dividers
  logic [7:0] cl_src, cl_map, off_src, off_map;
  logic       flat_src_q, flat_map_q;
  logic [7:0] den_src_q, den_map_q, drem_src_q, drem_map_q;
  logic [psbm_pkg::NumW-1:0] quo_src_q, quo_map_q;
  logic [8:0] tr_src, tr_map;
  logic       ge_src, ge_map;

  assign cl_src  = (lum_src_q < min_src_q) ? min_src_q :
                   (lum_src_q > max_src_q) ? max_src_q : lum_src_q;
  assign cl_map  = (lum_map_q < min_map_q) ? min_map_q :
                   (lum_map_q > max_map_q) ? max_map_q : lum_map_q;
  assign off_src = cl_src - min_src_q;
  assign off_map = cl_map - min_map_q;
  assign tr_src  = {drem_src_q, quo_src_q[psbm_pkg::NumW-1]};
  assign tr_map  = {drem_map_q, quo_map_q[psbm_pkg::NumW-1]};
  assign ge_src  = tr_src >= {1'b0, den_src_q};
  assign ge_map  = tr_map >= {1'b0, den_map_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_init) begin
      flat_src_q <= max_src_q <= min_src_q;
      flat_map_q <= max_map_q <= min_map_q;
      den_src_q  <= max_src_q - min_src_q;
      den_map_q  <= max_map_q - min_map_q;
      drem_src_q <= '0;
      drem_map_q <= '0;
      quo_src_q  <= {off_src, 8'd0} - {8'd0, off_src};
      quo_map_q  <= {off_map, 8'd0} - {8'd0, off_map};
    end else if (cmd_i.div_step) begin
      drem_src_q <= ge_src ? 8'(tr_src - {1'b0, den_src_q}) : tr_src[7:0];
      drem_map_q <= ge_map ? 8'(tr_map - {1'b0, den_map_q}) : tr_map[7:0];
      quo_src_q  <= {quo_src_q[psbm_pkg::NumW-2:0], ge_src};
      quo_map_q  <= {quo_map_q[psbm_pkg::NumW-2:0], ge_map};
    end
  end

  logic [7:0]  ns, nm, dl;
  logic [15:0] lum_err;
  logic [48:0] lum_add;
  logic [psbm_pkg::LumSumW-1:0] lum_sum_q;

  assign ns      = flat_src_q ? 8'd0 : quo_src_q[7:0];
  assign nm      = flat_map_q ? 8'd0 : quo_map_q[7:0];
  assign dl      = absdiff(ns, nm);
  assign lum_err = 16'(dl) * 16'(dl);
  assign lum_add = {1'b0, lum_sum_q} + 49'(lum_err);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_sum_q <= '0;
      lum_sum_q <= '0;
    end else if (cmd_i.close) begin
      ovl_sum_q <= '0;
      lum_sum_q <= '0;
    end else begin
      if (cmd_i.acc && inb_q && !cmd_q)
        ovl_sum_q <= ovl_add[40] ? '1 : ovl_add[39:0];
      if (cmd_i.lum_acc)
        lum_sum_q <= lum_add[48] ? '1 : lum_add[47:0];
    end
  end

  // shift-add blend
  logic [8:0] a_eff, wa_q, wb_q;
  logic [psbm_pkg::AccW-1:0] ovl_sh_q, lum_sh_q, acc_q;

  assign a_eff = (alpha_q > psbm_pkg::AlphaOne) ? psbm_pkg::AlphaOne : alpha_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_init) begin
      wa_q     <= a_eff;
      wb_q     <= psbm_pkg::AlphaOne - a_eff;
      ovl_sh_q <= psbm_pkg::AccW'(ovl_sum_q);
      lum_sh_q <= psbm_pkg::AccW'(lum_sum_q);
      acc_q    <= '0;
    end else if (cmd_i.blend_step) begin
      acc_q    <= acc_q + (wa_q[0] ? ovl_sh_q : '0) + (wb_q[0] ? lum_sh_q : '0);
      ovl_sh_q <= {ovl_sh_q[psbm_pkg::AccW-2:0], 1'b0};
      lum_sh_q <= {lum_sh_q[psbm_pkg::AccW-2:0], 1'b0};
      wa_q     <= {1'b0, wa_q[8:1]};
      wb_q     <= {1'b0, wb_q[8:1]};
    end
  end

  // closing and best search
  logic [psbm_pkg::ScoreW-1:0] score, best_q, cand_q, out_best_q;
  logic [11:0] bx_q, by_q, out_bx_q, out_by_q;
  logic        better;

  assign score  = !mode_q ? psbm_pkg::ScoreW'(ovl_sum_q) :
                  (acc_q[56] ? '1 : acc_q[55:8]);
  assign better = score < best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '1;
      bx_q   <= '0;
      by_q   <= '0;
    end else if (cmd_i.load && in_user_i[1]) begin
      best_q <= '1;
      bx_q   <= '0;
      by_q   <= '0;
    end else if (cmd_i.close && better) begin
      best_q <= score;
      bx_q   <= cx_q;
      by_q   <= cy_q;
    end
  end

  // result register, held until the request leaves
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      cand_q     <= score;
      out_best_q <= better ? score : best_q;
      out_bx_q   <= better ? cx_q : bx_q;
      out_by_q   <= better ? cy_q : by_q;
    end
  end

  assign out_data_o = {out_by_q, out_bx_q, out_best_q, cand_q};

endmodule

// ----- sv/patch_ssd_best_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_ssd_best_match
// Patch ssd error with optional luminance term and running best match.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata 72b, tuser 3b, tlast
// m_axis    out  tvalid/tready             tdata 120b
// cfg       in   cfg_valid/cfg_ready       cfg_index 3b, cfg_data 9b
//
// overlap pixel: intake and accumulate; correspondence pixel: also luminance
// multiply, fix, normalization setup, the 16-step restoring luminance
// dividers and luminance accumulate; closing adds a closing state, after a
// shift-add blend in correspondence mode; waits while output register is full
// reset clears sums, best score to all ones and registers to their defaults
// ----------------------------------------------------------------------------
module patch_ssd_best_match (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cand_x, cand_y, src_r, src_g, src_b, ref_r, ref_g, ref_b
  input  logic [71:0]  s_axis_tdata_i,
  // cmd, first_of_search, in_bounds
  input  logic [2:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // candidate_score, best_score, best_x, best_y
  output logic [119:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i
);

  psbm_pkg::dp_cmd_t    dp_cmd;
  psbm_pkg::dp_status_t dp_status;

  psbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  psbm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status)
  );

endmodule

// ----- dv/psbm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbm_checker
// Watches the pixel, result and register channels of patch_ssd_best_match.
// Keeps its own copy of the registers and accumulators, predicts the score
// and running best of every closing request, and compares field by field.
// ----------------------------------------------------------------------------
module psbm_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [71:0]  s_axis_tdata_i,
  input  logic [2:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [119:0] m_axis_tdata_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           results_o,
  output int           corr_pixels_o
);

  typedef struct packed {
    logic [psbm_pkg::CoordW-1:0] best_y;
    logic [psbm_pkg::CoordW-1:0] best_x;
    logic [psbm_pkg::ScoreW-1:0] best_score;
    logic [psbm_pkg::ScoreW-1:0] cand_score;
  } match_t;

  localparam logic [63:0] Sat40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] Sat48 = 64'hFFFF_FFFF_FFFF;

  logic        mode_q;
  logic [8:0]  alpha_q;
  logic [7:0]  src_lo_q, src_hi_q, map_lo_q, map_hi_q;
  logic [63:0] ovl_acc, lum_acc, best_err;
  logic [11:0] best_col, best_row;
  match_t      expected_matches[$];

  function automatic logic [63:0] luminance(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [63:0] w;
    w = 64'd2126 * 64'(r) + 64'd7152 * 64'(g) + 64'd722 * 64'(b);
    return w / 64'd10000;
  endfunction

  function automatic logic [63:0] norm_lum(logic [63:0] v, logic [7:0] lo, logic [7:0] hi);
    if (hi <= lo) return 64'd0;
    if (v < 64'(lo)) v = 64'(lo);
    if (v > 64'(hi)) v = 64'(hi);
    return ((v - 64'(lo)) * 64'd255) / (64'(hi) - 64'(lo));
  endfunction

  function automatic logic [63:0] sq_diff(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
    fail_count_o++;
  endtask

  task automatic predict_pixel();
    logic [63:0] e, ns, nm, a, score;
    logic [7:0]  sr, sg, sb, rr, rg, rb;
    match_t      m;
    {rb, rg, rr, sb, sg, sr} = s_axis_tdata_i[71:24];
    if (s_axis_tuser_i[1]) begin
      best_err = Sat48;
      best_col = '0;
      best_row = '0;
    end
    if (s_axis_tuser_i[2]) begin
      if (!s_axis_tuser_i[0]) begin
        e = sq_diff(64'(sr), 64'(rr)) + sq_diff(64'(sg), 64'(rg)) + sq_diff(64'(sb), 64'(rb));
        ovl_acc = (ovl_acc + e > Sat40) ? Sat40 : ovl_acc + e;
      end else if (mode_q) begin
        corr_pixels_o++;
        ns = norm_lum(luminance(sr, sg, sb), src_lo_q, src_hi_q);
        nm = norm_lum(luminance(rr, rg, rb), map_lo_q, map_hi_q);
        e = sq_diff(ns, nm);
        lum_acc = (lum_acc + e > Sat48) ? Sat48 : lum_acc + e;
      end
    end
    if (s_axis_tlast_i) begin
      if (mode_q) begin
        a = (alpha_q > psbm_pkg::AlphaOne) ? 64'd256 : 64'(alpha_q);
        score = (a * ovl_acc + (64'd256 - a) * lum_acc) >> 8;
        if (score > Sat48) score = Sat48;
      end else begin
        score = ovl_acc;
      end
      if (score < best_err) begin
        best_err = score;
        best_col = s_axis_tdata_i[11:0];
        best_row = s_axis_tdata_i[23:12];
      end
      m.cand_score = score[47:0];
      m.best_score = best_err[47:0];
      m.best_x = best_col;
      m.best_y = best_row;
      expected_matches = {expected_matches, m};
      ovl_acc = '0;
      lum_acc = '0;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
    corr_pixels_o = 0;
    mode_q = 1'b0;
    alpha_q = 9'd128;
    src_lo_q = 8'd0;
    src_hi_q = 8'd255;
    map_lo_q = 8'd0;
    map_hi_q = 8'd255;
    ovl_acc = '0;
    lum_acc = '0;
    best_err = Sat48;
    best_col = '0;
    best_row = '0;
  end

  always @(posedge clk_i) begin
    match_t m, got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          psbm_pkg::RegMode:   mode_q = cfg_data_i[0];
          psbm_pkg::RegAlpha:  alpha_q = cfg_data_i;
          psbm_pkg::RegMinSrc: src_lo_q = cfg_data_i[7:0];
          psbm_pkg::RegMaxSrc: src_hi_q = cfg_data_i[7:0];
          psbm_pkg::RegMinMap: map_lo_q = cfg_data_i[7:0];
          psbm_pkg::RegMaxMap: map_hi_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o++;
        got = m_axis_tdata_i;
        if (expected_matches.size() == 0) begin
          report("unexpected result", 64'd0, 64'(got.cand_score));
        end else begin
          m = expected_matches.pop_front();
          if (got.cand_score != m.cand_score)
            report("candidate_score", 64'(m.cand_score), 64'(got.cand_score));
          if (got.best_score != m.best_score)
            report("best_score", 64'(m.best_score), 64'(got.best_score));
          if (got.best_x != m.best_x) report("best_x", 64'(m.best_x), 64'(got.best_x));
          if (got.best_y != m.best_y) report("best_y", 64'(m.best_y), 64'(got.best_y));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_pixel();
      pending_o = expected_matches.size();
    end
  end

endmodule

// ----- dv/patch_ssd_best_match_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_ssd_best_match_tb
// Streams candidate tiles of pixel pairs through patch_ssd_best_match over
// several register settings, with bursty input and a stalling receiver; the
// checker predicts every score and running best and counts mismatches.
// ----------------------------------------------------------------------------
module patch_ssd_best_match_tb;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 60;
  localparam int RandItems = 1550;
  localparam int NumPhases = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [71:0]  s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [119:0] m_axis_tdata_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [8:0]   cfg_data_i = '0;

  int fail_count, pending, results, corr_pixels;
  int burst_left = 0;
  int sent = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_timer = 0;
  logic cur_mode = 1'b0;

  patch_ssd_best_match dut (.*);

  psbm_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .corr_pixels_o(corr_pixels)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stall pattern, switching style every so often
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 150);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no progress, %0d results outstanding", pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(logic cmd, logic first, logic inb, logic last,
                            logic [11:0] x, logic [11:0] y,
                            logic [23:0] src, logic [23:0] ref_px);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {ref_px, src, y, x};
    s_axis_tuser_i <= {inb, first, cmd};
    s_axis_tlast_i <= last;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    @(posedge clk_i);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] rand_rgb();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic logic [7:0] rand_lum_bound();
    return ($urandom_range(0, 3) == 0) ? rand_chan() : 8'($urandom_range(0, 255));
  endfunction

  task automatic set_regs(logic mode, logic [8:0] alpha, logic [7:0] slo, logic [7:0] shi,
                          logic [7:0] mlo, logic [7:0] mhi);
    write_reg(psbm_pkg::RegMode, {8'd0, mode});
    write_reg(psbm_pkg::RegAlpha, alpha);
    write_reg(psbm_pkg::RegMinSrc, {1'b0, slo});
    write_reg(psbm_pkg::RegMaxSrc, {1'b0, shi});
    write_reg(psbm_pkg::RegMinMap, {1'b0, mlo});
    write_reg(psbm_pkg::RegMaxMap, {1'b0, mhi});
    cur_mode = mode;
  endtask

  // one candidate tile: a few pixel pairs, closed by the last one
  task automatic send_candidate(logic first, int len);
    logic [11:0] x, y;
    logic [23:0] s, r;
    logic        cmd, inb, flat;
    x = 12'($urandom_range(0, 4095));
    y = 12'($urandom_range(0, 4095));
    flat = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      s = rand_rgb();
      r = (flat || $urandom_range(0, 4) == 0) ? s : rand_rgb();
      cmd = cur_mode ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
      inb = ($urandom_range(0, 7) != 0);
      send_pixel(cmd, first && i == 0, inb, i == len - 1, x, y, s, r);
    end
  endtask

  initial begin
    int left;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, extremes, bounds, plain-mode correspondence, ties
    send_pixel(1'b0, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 24'h000000, 24'hFFFFFF);
    send_pixel(1'b0, 1'b0, 1'b0, 1'b0, 12'd1, 12'd2, 24'h000000, 24'hFFFFFF);
    send_pixel(1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 12'd2, 24'hFFFFFF, 24'h000000);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'd1, 12'd2, 24'h123456, 24'h123456);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'd3, 12'd4, 24'hABCDEF, 24'hABCDEF);
    send_pixel(1'b0, 1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'hFFF, 12'd0, 24'hFFFFFF, 24'h000000);
    drain();

    set_regs(1'b1, 9'd128, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel(1'b1, 1'b1, 1'b1, 1'b0, 12'd5, 12'd6, 24'hFFFFFF, 24'h000000);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'd5, 12'd6, 24'h00FF00, 24'hFF00FF);
    send_pixel(1'b1, 1'b0, 1'b1, 1'b1, 12'd7, 12'd8, 24'h0000FF, 24'hFF0000);
    drain();
    set_regs(1'b1, 9'd511, 8'd100, 8'd100, 8'd200, 8'd50);
    send_pixel(1'b1, 1'b1, 1'b1, 1'b0, 12'd9, 12'd9, 24'h808080, 24'hFFFFFF);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'd9, 12'd9, 24'h808080, 24'h000000);
    drain();
    set_regs(1'b1, 9'd0, 8'd60, 8'd90, 8'd0, 8'd1);
    send_pixel(1'b1, 1'b1, 1'b1, 1'b0, 12'd10, 12'd11, 24'h000000, 24'h010101);
    send_pixel(1'b1, 1'b0, 1'b1, 1'b0, 12'd10, 12'd11, 24'hFFFFFF, 24'h000000);
    send_pixel(1'b0, 1'b0, 1'b1, 1'b1, 12'd10, 12'd11, 24'hFFFFFF, 24'h000000);
    drain();
    write_reg(RegUnused, 9'h1FF);

    // random phases, each ending on a closed candidate
    left = RandItems;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_regs(1'b0, 9'd128, 8'd0, 8'd255, 8'd0, 8'd255);
        1: set_regs(1'b1, 9'd256, 8'd0, 8'd255, 8'd0, 8'd255);
        2: set_regs(1'b1, 9'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        3: set_regs(1'b1, 9'd511, 8'd250, 8'd255, 8'd0, 8'd1);
        4: set_regs(1'b0, 9'd300, 8'd17, 8'd3, 8'd0, 8'd255);
        default: set_regs(1'b1, 9'($urandom_range(0, 511)), rand_lum_bound(),
                          rand_lum_bound(), rand_lum_bound(), rand_lum_bound());
      endcase
      while (left > (NumPhases - 1 - p) * RandItems / NumPhases) begin
        int len;
        len = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          // noise: stray search starts and lone pixels
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     rand_rgb(), rand_rgb());
          len = 1;
        end else begin
          send_candidate($urandom_range(0, 4) == 0, len);
        end
        left -= len;
        if (p == 3 && left % 50 < len) begin
          // hold off until every pending result is back
          s_axis_tvalid_i <= 1'b0;
          burst_left = 0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("sent %0d pixel pairs over %0d register settings", sent, NumPhases + 4);
    $display("checked %0d results, %0d luminance pairs", results, corr_pixels);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/psbm_pkg.sv
sv/psbm_ctrl.sv
sv/psbm_dp.sv
sv/patch_ssd_best_match.sv
dv/psbm_checker.sv
dv/patch_ssd_best_match_tb.sv
